FILE: sv/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and constants of the shifting array table: item structs,
// command and status codes, default sizes
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_SEARCH = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [7:0]         slot;
        logic signed [31:0] word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [6:0]         position;
        logic signed [31:0] data_out;
        logic [7:0]         count;
    } t_out_item;

endpackage

FILE: sv/sat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram
// simple dual-port synchronous ram, one write and one read port, registered
// read data
// ----------------------------------------------------------------------------
module sat_ram #(
    parameter int DEPTH = sat_pkg::DEF_CAPACITY,
    parameter int WIDTH = sat_pkg::DEF_DATA_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/shifting_array_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_array_table_top
// packed table of signed words with clear, append, insert, delete, search
// and read commands, one result item per command item
// ----------------------------------------------------------------------------
// The table lives in one simple dual-port RAM of CAPACITY words; a register
// holds the count of entries in use. One command item is taken at a time and
// gives exactly one result item. Insert and delete move the tail one entry
// per cycle through the RAM (read one entry, write it one place up or down
// in the next cycle). A search reads entries from index 0 one per cycle and
// stops at the first hit. The single RAM read and write port sets that pace.
// The result sits in an output register, so the next item is taken while a
// finished result still waits for the output side.
// ----------------------------------------------------------------------------
module shifting_array_table_top #(
    parameter int CAPACITY   = sat_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = sat_pkg::DEF_DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sat_pkg::t_in_item   i_in_item,
    // result side
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sat_pkg::t_out_item  o_out_item
);

    import sat_pkg::*;

    // counters hold 0..CAPACITY, ram addresses 0..CAPACITY-1
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    // common width for comparing the 8-bit slot with the count
    localparam int CW = (UW > 8) ? UW : 8;

    // controller states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a command item
        S_EXEC = 4'b0010,   // checks and single-step commands
        S_WALK = 4'b0100,   // ram walk for insert, delete, search, read
        S_DONE = 4'b1000    // hand the result to the output register
    } t_state;

    t_state                 r_state, n_state;
    logic [2:0]             r_cmd, n_cmd;
    logic [7:0]             r_slot, n_slot;
    logic [DATA_WIDTH-1:0]  r_word, n_word;     // word in stored form
    logic [UW-1:0]          r_used, n_used;
    logic [UW-1:0]          r_ptr, n_ptr;       // walk pointer: next ram address to read, for insert one above it
    logic [UW-1:0]          r_tag, n_tag;       // address of data in flight
    logic                   r_pend, n_pend;     // ram read data is valid
    logic [1:0]             r_status, n_status;
    logic                   r_found, n_found;
    logic [6:0]             r_pos, n_pos;
    logic signed [31:0]     r_data, n_data;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    // ram port signals
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DATA_WIDTH-1:0]  wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [DATA_WIDTH-1:0]  rd_data;

    // helpers
    logic                   in_accept;
    logic                   out_free;
    logic [CW-1:0]          slot_cmp;
    logic [CW-1:0]          used_cmp;
    logic [UW-1:0]          slot_u;
    logic                   is_empty;
    logic                   is_full;

    sat_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    // the output register can take a new result this cycle
    assign out_free  = !r_out_valid || !i_out_stall;

    assign slot_cmp = CW'(r_slot);
    assign used_cmp = CW'(r_used);
    // only used once the slot is known to lie below or at the count
    assign slot_u   = UW'(r_slot);
    assign is_empty = (r_used == '0);
    assign is_full  = (r_used == UW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_word      = r_word;
        n_used      = r_used;
        n_ptr       = r_ptr;
        n_tag       = r_tag;
        n_pend      = r_pend;
        n_status    = r_status;
        n_found     = r_found;
        n_pos       = r_pos;
        n_data      = r_data;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        wr_en   = 1'b0;
        wr_addr = AW'(r_used);
        wr_data = r_word;
        rd_en   = 1'b0;
        rd_addr = AW'(r_ptr);

        // result leaves when the output side takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd   = i_in_item.cmd;
                    n_slot  = i_in_item.slot;
                    // sign-extend or cut the 32-bit word to the stored width
                    n_word  = DATA_WIDTH'(i_in_item.word);
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_pos    = '0;
                n_data   = '0;
                n_pend   = 1'b0;
                n_state  = S_DONE;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_used = '0;
                    end
                    CMD_APPEND: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            // new word goes right after the last entry
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_used);
                            wr_data = r_word;
                            n_used  = r_used + UW'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else if (is_full) begin
                            n_status = ST_FULL;
                        end else if (slot_cmp > used_cmp) begin
                            n_status = ST_RANGE;
                        end else begin
                            // shift the tail up, starting at the top
                            n_ptr   = r_used;
                            n_state = S_WALK;
                        end
                    end
                    CMD_DELETE: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else if (slot_cmp >= used_cmp) begin
                            n_status = ST_RANGE;
                        end else begin
                            // shift the tail down, starting above the hole
                            n_ptr   = slot_u + UW'(1);
                            n_state = S_WALK;
                        end
                    end
                    CMD_SEARCH: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_ptr   = '0;
                            n_state = S_WALK;
                        end
                    end
                    CMD_READ: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else if (slot_cmp >= used_cmp) begin
                            n_status = ST_RANGE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(slot_u);
                            n_tag   = slot_u;
                            n_pend  = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        // unknown codes only report the count
                    end
                endcase
            end

            S_WALK: begin
                case (r_cmd)
                    CMD_INSERT: begin
                        // write back the entry read last cycle, one place up
                        if (r_pend) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_tag + UW'(1));
                            wr_data = rd_data;
                        end else if (r_ptr == slot_u) begin
                            // tail moved, drop the new word into the gap
                            wr_en   = 1'b1;
                            wr_addr = AW'(slot_u);
                            wr_data = r_word;
                            n_used  = r_used + UW'(1);
                            n_state = S_DONE;
                        end
                        if (r_ptr > slot_u) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_ptr - UW'(1));
                            n_tag   = r_ptr - UW'(1);
                            n_ptr   = r_ptr - UW'(1);
                            n_pend  = 1'b1;
                        end else begin
                            n_pend  = 1'b0;
                        end
                    end
                    CMD_DELETE: begin
                        // write back the entry read last cycle, one place down
                        if (r_pend) begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_tag - UW'(1));
                            wr_data = rd_data;
                        end
                        if (r_ptr < r_used) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_ptr);
                            n_tag   = r_ptr;
                            n_ptr   = r_ptr + UW'(1);
                            n_pend  = 1'b1;
                        end else begin
                            n_pend  = 1'b0;
                            if (!r_pend) begin
                                n_used  = r_used - UW'(1);
                                n_state = S_DONE;
                            end
                        end
                    end
                    CMD_SEARCH: begin
                        if (r_pend && (rd_data == r_word)) begin
                            // first hit ends the scan
                            n_found = 1'b1;
                            n_pos   = 7'(r_tag);
                            n_state = S_DONE;
                        end else if (r_ptr < r_used) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_ptr);
                            n_tag   = r_ptr;
                            n_ptr   = r_ptr + UW'(1);
                            n_pend  = 1'b1;
                        end else begin
                            n_pend  = 1'b0;
                            if (!r_pend) begin
                                n_state = S_DONE;
                            end
                        end
                    end
                    CMD_READ: begin
                        // widen the stored word back to 32 bits
                        n_data  = 32'(signed'(rd_data));
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.found     = r_found;
                    n_out.position  = r_pos;
                    n_out.data_out  = r_data;
                    n_out.count     = 8'(r_used);
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read data only counts while walking
        if (n_state != S_WALK) begin
            n_pend = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_slot   <= n_slot;
        r_word   <= n_word;
        r_ptr    <= n_ptr;
        r_tag    <= n_tag;
        r_status <= n_status;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_data   <= n_data;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(CAPACITY))
        else $error("entry count above capacity");

    // ram read data is only tracked during a walk
    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WALK))
        else $error("read data pending outside a walk");

    // a fresh result reports the current count
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out.count == 8'(r_used)))
        else $error("result count differs from table count");

    // a search hit is an ok result inside the table
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_out.found) |->
            ((r_out.status == ST_OK) && (UW'(r_out.position) < r_used)))
        else $error("search hit with bad status or position");

endmodule
